/* hw/rtl/sha1md_pkg.sv */
// SHA-1 message digest: shared types, sequencer states and round constants.
// No dependencies; imported by the response channel interface and the top level.
`timescale 1ns / 1ps

package sha1md_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int HASH_WORDS  = 5;
   localparam int ROUNDS      = 80;
   localparam int COUNT_WIDTH = 61;

   localparam logic [WORD_WIDTH-1:0] K_ROUND_0 = 32'h5A827999;
   localparam logic [WORD_WIDTH-1:0] K_ROUND_1 = 32'h6ED9EBA1;
   localparam logic [WORD_WIDTH-1:0] K_ROUND_2 = 32'h8F1BBCDC;
   localparam logic [WORD_WIDTH-1:0] K_ROUND_3 = 32'hCA62C1D6;

   localparam logic [WORD_WIDTH-1:0] SHA1_IV [HASH_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] BLOCK_END = 6'd63;
   localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
   localparam logic [2:0] LAST_WORD_IDX = 3'(HASH_WORDS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef logic [WORD_WIDTH-1:0] word_type;

   function automatic word_type round_fn(input logic [6:0] rnd, input word_type b,
                                         input word_type c, input word_type d);
      word_type f;
      if (rnd < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(input logic [6:0] rnd);
      word_type k;
      if (rnd < 7'd20) begin
         k = K_ROUND_0;
      end else if (rnd < 7'd40) begin
         k = K_ROUND_1;
      end else if (rnd < 7'd60) begin
         k = K_ROUND_2;
      end else begin
         k = K_ROUND_3;
      end
      return k;
   endfunction

endpackage

/* hw/rtl/sha1md_if.sv */
// SHA-1 message digest: request and response channel interfaces.
// Depends on sha1md_pkg for the word type.
`timescale 1ns / 1ps

interface sha1md_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha1md_rsp_if
   import sha1md_pkg::*;
   ;
   logic       valid;
   logic       ready;
   word_type   digest_word;
   logic [2:0] word_number;
   logic       last_word;

   modport source (output valid, output digest_word, output word_number,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_number,
                   input last_word, output ready);
endinterface

/* hw/rtl/sha1_message_digest.sv */
// SHA-1 message digest top level: byte packer, padder, shared round unit.
// Depends on sha1md_pkg and the channel interfaces in sha1md_if.sv.
// A data byte is packed into the block; the byte that fills a block starts
// a compression (load, 80 rounds at one round per cycle, chaining update).
// A finish request pads the message, runs one or two compressions, then
// emits the five digest words. Requests are taken only while idle, not
// during padding, compression or the response.
// Reset (synchronous): idle, initial hash values, all counts cleared.
`timescale 1ns / 1ps

module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   sha1md_req_if.sink        req,
   sha1md_rsp_if.source      rsp
);

   state_type              state_ff, state_in;
   word_type               msg_ff [BLOCK_WORDS];
   word_type               msg_in [BLOCK_WORDS];
   word_type               h_ff [HASH_WORDS];
   word_type               h_in [HASH_WORDS];
   word_type               v_ff [HASH_WORDS];
   word_type               v_in [HASH_WORDS];
   logic [5:0]             cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [6:0]             round_ff, round_in;
   logic [2:0]             idx_ff, idx_in;
   logic                   fin_ff, fin_in;
   logic                   len_ff, len_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   shift_byte;
   logic [7:0]             byte_val;
   logic [63:0]            bit_len;
   logic [63:0]            len_shift;
   word_type               sched;
   word_type               temp;

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign bit_len  = {count_ff, 3'b000};
   assign len_shift = bit_len >> {3'd7 - cnt_ff[2:0], 3'b000};
   assign sched = {msg_ff[13][30:0] ^ msg_ff[8][30:0] ^ msg_ff[2][30:0] ^ msg_ff[0][30:0],
                   msg_ff[13][31] ^ msg_ff[8][31] ^ msg_ff[2][31] ^ msg_ff[0][31]};
   assign temp = {v_ff[0][26:0], v_ff[0][31:27]}
               + round_fn(round_ff, v_ff[1], v_ff[2], v_ff[3])
               + v_ff[4] + round_k(round_ff) + msg_ff[0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (cnt_ff == BLOCK_END) begin
                  state_in = ST_LOAD;
               end else if (req.kind) begin
                  state_in = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_ZERO: begin
            if (cnt_ff == LEN_START) begin
               state_in = ST_PAD_LEN;
            end else if (cnt_ff == BLOCK_END) begin
               state_in = ST_LOAD;
            end
         end
         ST_PAD_LEN: begin
            if (cnt_ff == BLOCK_END) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && idx_ff == LAST_WORD_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready       = (state_ff == ST_IDLE);
      rsp.valid       = (state_ff == ST_EMIT);
      rsp.digest_word = h_ff[idx_ff];
      rsp.word_number = idx_ff;
      rsp.last_word   = (idx_ff == LAST_WORD_IDX);
   end

   // datapath
   always_comb begin
      shift_byte = 1'b0;
      byte_val   = 8'h00;
      msg_in     = msg_ff;
      h_in       = h_ff;
      v_in       = v_ff;
      cnt_in     = cnt_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      fin_in     = fin_ff;
      len_in     = len_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               shift_byte = 1'b1;
               if (req.kind) begin
                  byte_val = PAD_MARK;
                  fin_in   = 1'b1;
               end else begin
                  byte_val = req.data_byte;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_PAD_ZERO: begin
            shift_byte = (cnt_ff != LEN_START);
         end
         ST_PAD_LEN: begin
            shift_byte = 1'b1;
            byte_val   = len_shift[7:0];
            len_in     = 1'b1;
         end
         ST_LOAD: begin
            v_in     = h_ff;
            round_in = '0;
         end
         ST_ROUND: begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               msg_in[i] = msg_ff[i+1];
            end
            msg_in[BLOCK_WORDS-1] = sched;
            v_in[0] = temp;
            v_in[1] = v_ff[0];
            v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3];
            round_in = (round_ff == LAST_ROUND) ? '0 : round_ff + 1'b1;
         end
         ST_UPDATE: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (idx_ff == LAST_WORD_IDX) begin
                  idx_in   = '0;
                  h_in     = SHA1_IV;
                  cnt_in   = '0;
                  count_in = '0;
                  fin_in   = 1'b0;
                  len_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (shift_byte) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            msg_in[i] = {msg_ff[i][23:0], msg_ff[i+1][31:24]};
         end
         msg_in[BLOCK_WORDS-1] = {msg_ff[BLOCK_WORDS-1][23:0], byte_val};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      v_ff   <= v_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff     <= SHA1_IV;
         cnt_ff   <= '0;
         count_ff <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         fin_ff   <= 1'b0;
         len_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         fin_ff   <= fin_in;
         len_ff   <= len_in;
      end
   end

endmodule
